// ===== rtl/core/lrupr_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lrupr_pkg
// Shared types and constants for the lru page replacement block.
// ----------------------------------------------------------------------------
package lrupr_pkg;

  localparam int FRAMES    = 8;
  localparam int PAGE_BITS = 16;
  localparam int SLOT_W    = (FRAMES > 1) ? $clog2(FRAMES) : 1;
  localparam int RANK_W    = SLOT_W;
  localparam int CNT_W     = 4;
  localparam int FAULT_W   = 32;

  localparam logic [RANK_W-1:0]  RANK_MAX  = RANK_W'(FRAMES - 1);
  localparam logic [SLOT_W-1:0]  SLOT_LAST = SLOT_W'(FRAMES - 1);
  localparam logic [CNT_W-1:0]   CNT_RESET = CNT_W'(FRAMES);
  localparam logic [FAULT_W-1:0] FAULT_MAX = '1;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_LOOK,
    ST_AGE,
    ST_EMIT
  } state_t;

  typedef struct packed {
    logic                 valid;
    logic [PAGE_BITS-1:0] page;
    logic [RANK_W-1:0]    rank;
  } frame_t;

  typedef struct packed {
    logic              hit;
    logic [SLOT_W-1:0] hit_slot;
    logic [RANK_W-1:0] hit_rank;
    logic              emp;
    logic [SLOT_W-1:0] emp_slot;
    logic [RANK_W-1:0] old_rank;
    logic [SLOT_W-1:0] old_slot;
  } scan_t;

  typedef struct packed {
    logic              miss;
    logic              cold;
    logic [SLOT_W-1:0] slot;
    logic [RANK_W-1:0] limit;
  } age_ctl_t;

endpackage

// ===== rtl/core/lrupr_frame_unit.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lrupr_frame_unit
// Per-frame compare and age unit, shared by the lookup and age passes.
// ----------------------------------------------------------------------------
module lrupr_frame_unit import lrupr_pkg::*; (
  input  logic [SLOT_W-1:0]    idx,
  input  frame_t               ent,
  input  logic [PAGE_BITS-1:0] page,
  input  scan_t                scan_i,
  input  age_ctl_t             ctl,
  output scan_t                scan_o,
  output frame_t               ent_o
);

  // lookup pass: first match, first empty, oldest with lowest index
  always_comb begin
    scan_o = scan_i;
    if (ent.valid && (ent.page == page) && !scan_i.hit) begin
      scan_o.hit      = 1'b1;
      scan_o.hit_slot = idx;
      scan_o.hit_rank = ent.rank;
    end
    if (!ent.valid && !scan_i.emp) begin
      scan_o.emp      = 1'b1;
      scan_o.emp_slot = idx;
    end
    if ((idx == '0) || (ent.rank > scan_i.old_rank)) begin
      scan_o.old_rank = ent.rank;
      scan_o.old_slot = idx;
    end
  end

  // age pass
  always_comb begin
    ent_o = ent;
    if (idx == ctl.slot) begin
      ent_o.rank = '0;
      if (ctl.miss) begin
        ent_o.page  = page;
        ent_o.valid = 1'b1;
      end
    end else if (ent.valid && (ent.rank != RANK_MAX) &&
                 (ctl.cold || (ent.rank < ctl.limit))) begin
      ent_o.rank = ent.rank + RANK_W'(1);
    end
  end

endmodule

// ===== rtl/core/lru_page_replacement.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lru_page_replacement
// LRU page replacement over FRAMES page frames, one reference per transfer.
// One frame unit visits a frame per cycle, once in the lookup pass and once in
// the age pass; a new reference is taken only in the idle state, after the
// previous one has passed its lookup, age and emit states.
// Reset: synchronous; frames empty, ages and fault count zero, frame count 8.
// ----------------------------------------------------------------------------
module lru_page_replacement import lrupr_pkg::*; (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CNT_W-1:0]     cfg_frame_count,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  logic [PAGE_BITS-1:0] in_page_id,
  output logic                 out_valid,
  input  logic                 out_stall,
  output logic                 out_hit,
  output logic [2:0]           out_frame_slot,
  output logic                 out_filled_empty,
  output logic [FAULT_W-1:0]   out_fault_count
);

  state_t               state_r, state_nxt;
  logic [CNT_W-1:0]     frame_count_r;
  logic [FRAMES-1:0]    valid_r;
  logic [RANK_W-1:0]    rank_r [FRAMES];
  logic [PAGE_BITS-1:0] page_r [FRAMES];
  logic [SLOT_W-1:0]    idx_r;
  logic [SLOT_W-1:0]    last_r;
  logic [SLOT_W-1:0]    last_nxt;
  logic [PAGE_BITS-1:0] page_in_r;
  scan_t                scan_r;
  logic [FAULT_W-1:0]   fault_r;
  logic                 out_valid_r;
  logic                 out_hit_r;
  logic [2:0]           out_slot_r;
  logic                 out_cold_r;
  logic [FAULT_W-1:0]   out_fault_r;

  frame_t               ent_cur;
  frame_t               ent_new;
  scan_t                scan_new;
  age_ctl_t             ctl;
  logic                 in_xfer;
  logic                 out_xfer;
  logic                 scan_end;
  logic                 emit_go;

  assign in_xfer  = in_valid && !in_stall;
  assign out_xfer = out_valid_r && !out_stall;
  assign scan_end = (idx_r == last_r);
  assign emit_go  = !out_valid_r || !out_stall;

  // frames in use, clamped to 1..FRAMES
  always_comb begin
    if (frame_count_r == '0) begin
      last_nxt = '0;
    end else if (frame_count_r > CNT_RESET) begin
      last_nxt = SLOT_LAST;
    end else begin
      last_nxt = SLOT_W'(frame_count_r - CNT_W'(1));
    end
  end

  assign ent_cur.valid = valid_r[idx_r];
  assign ent_cur.page  = page_r[idx_r];
  assign ent_cur.rank  = rank_r[idx_r];

  always_comb begin
    ctl.miss  = !scan_r.hit;
    ctl.cold  = !scan_r.hit && scan_r.emp;
    if (scan_r.hit) begin
      ctl.slot  = scan_r.hit_slot;
      ctl.limit = scan_r.hit_rank;
    end else if (scan_r.emp) begin
      ctl.slot  = scan_r.emp_slot;
      ctl.limit = RANK_MAX;
    end else begin
      ctl.slot  = scan_r.old_slot;
      ctl.limit = scan_r.old_rank;
    end
  end

  lrupr_frame_unit u_frame (
    .idx    (idx_r),
    .ent    (ent_cur),
    .page   (page_in_r),
    .scan_i (scan_r),
    .ctl    (ctl),
    .scan_o (scan_new),
    .ent_o  (ent_new)
  );

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: if (in_xfer) state_nxt = ST_LOOK;
      ST_LOOK: if (scan_end) state_nxt = ST_AGE;
      ST_AGE:  if (scan_end) state_nxt = ST_EMIT;
      ST_EMIT: if (emit_go) state_nxt = ST_IDLE;
      default: state_nxt = ST_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    in_stall = 1'b1;
    case (state_r)
      ST_IDLE: in_stall = 1'b0;
      default: in_stall = 1'b1;
    endcase
  end

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= ST_IDLE;
      frame_count_r <= CNT_RESET;
      valid_r       <= '0;
      fault_r       <= '0;
      out_valid_r   <= 1'b0;
      idx_r         <= '0;
      for (int i = 0; i < FRAMES; i++) begin
        rank_r[i] <= '0;
      end
    end else begin
      state_r <= state_nxt;
      if (cfg_valid && cfg_ready) begin
        frame_count_r <= cfg_frame_count;
      end
      case (state_r)
        ST_IDLE: begin
          idx_r <= '0;
        end
        ST_LOOK: begin
          idx_r <= scan_end ? '0 : idx_r + SLOT_W'(1);
        end
        ST_AGE: begin
          valid_r[idx_r] <= ent_new.valid;
          rank_r[idx_r]  <= ent_new.rank;
          idx_r          <= scan_end ? '0 : idx_r + SLOT_W'(1);
          if (scan_end && ctl.miss && (fault_r != FAULT_MAX)) begin
            fault_r <= fault_r + FAULT_W'(1);
          end
        end
        default: begin
          idx_r <= '0;
        end
      endcase
      if ((state_r == ST_EMIT) && emit_go) begin
        out_valid_r <= 1'b1;
      end else if (out_xfer) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (in_xfer) begin
      page_in_r <= in_page_id;
      last_r    <= last_nxt;
      scan_r    <= '0;
    end else if (state_r == ST_LOOK) begin
      scan_r <= scan_new;
    end
    if (state_r == ST_AGE) begin
      page_r[idx_r] <= ent_new.page;
    end
    if ((state_r == ST_EMIT) && emit_go) begin
      out_hit_r   <= !ctl.miss;
      out_slot_r  <= 3'(ctl.slot);
      out_cold_r  <= ctl.cold;
      out_fault_r <= fault_r;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_hit          = out_hit_r;
  assign out_frame_slot   = out_slot_r;
  assign out_filled_empty = out_cold_r;
  assign out_fault_count  = out_fault_r;

  a_emit_source: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r == ST_EMIT))
    else $error("result raised outside emit state");

  a_fault_monotonic: assert property (@(posedge clk) disable iff (!rst_n)
    $past(rst_n) |-> (fault_r >= $past(fault_r)))
    else $error("fault count went down");

  a_hit_not_cold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_hit_r |-> !out_cold_r)
    else $error("hit flagged as cold fill");

  a_scan_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_LOOK || state_r == ST_AGE) |-> (idx_r <= last_r))
    else $error("scan index past frames in use");

endmodule

// ===== tb/lru_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lru_checker
// Watches the configuration, reference and result channels of the lru page
// replacement block. Keeps its own frame table, predicts hit, slot, cold fill
// and fault count for every reference transfer, and compares each result
// transfer against the oldest prediction. Hands the failure count and the
// number of outstanding predictions to the testbench top.
// ----------------------------------------------------------------------------
module lru_checker import lrupr_pkg::*; (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 cfg_valid,
  input  logic                 cfg_ready,
  input  logic [CNT_W-1:0]     cfg_frame_count,
  input  logic                 in_valid,
  input  logic                 in_stall,
  input  logic [PAGE_BITS-1:0] in_page_id,
  input  logic                 out_valid,
  input  logic                 out_stall,
  input  logic                 out_hit,
  input  logic [2:0]           out_frame_slot,
  input  logic                 out_filled_empty,
  input  logic [FAULT_W-1:0]   out_fault_count,
  output int                   fails,
  output int                   pending
);

  typedef struct packed {
    logic               hit;
    logic [2:0]         slot;
    logic               cold;
    logic [FAULT_W-1:0] faults;
  } ref_outcome_t;

  logic [PAGE_BITS-1:0] frame_page [FRAMES];
  logic                 frame_used [FRAMES];
  logic [RANK_W-1:0]    frame_age  [FRAMES];
  logic [FAULT_W-1:0]   fault_tally;
  logic [CNT_W-1:0]     frame_limit;
  ref_outcome_t         outcome_q [$];
  int                   fail_cnt = 0;

  function automatic int frames_in_use();
    int n;
    n = int'(frame_limit);
    if (n < 1) n = 1;
    if (n > FRAMES) n = FRAMES;
    return n;
  endfunction

  // age younger frames in use, then make slot the newest
  function automatic void age_frames(int n, int slot, int bound);
    for (int i = 0; i < n; i++) begin
      if (i != slot && frame_used[i] && int'(frame_age[i]) < bound &&
          frame_age[i] < RANK_MAX)
        frame_age[i] = frame_age[i] + RANK_W'(1);
    end
    frame_age[slot] = '0;
  endfunction

  function automatic ref_outcome_t replace_page(logic [PAGE_BITS-1:0] page);
    int           n;
    int           slot;
    bit           found;
    bit           cold;
    int           oldest;
    ref_outcome_t r;
    n = frames_in_use();
    slot = 0;
    found = 0;
    cold = 0;
    for (int i = 0; i < n; i++) begin
      if (!found && frame_used[i] && frame_page[i] == page) begin
        slot = i;
        found = 1;
      end
    end
    if (found) begin
      age_frames(n, slot, int'(frame_age[slot]));
    end else begin
      for (int i = 0; i < n; i++) begin
        if (!cold && !frame_used[i]) begin
          slot = i;
          cold = 1;
        end
      end
      if (cold) begin
        frame_used[slot] = 1'b1;
        frame_age[slot] = '0;
        age_frames(n, slot, FRAMES);
      end else begin
        oldest = int'(frame_age[0]);
        slot = 0;
        for (int i = 1; i < n; i++) begin
          if (int'(frame_age[i]) > oldest) begin
            oldest = int'(frame_age[i]);
            slot = i;
          end
        end
        age_frames(n, slot, oldest);
      end
      frame_page[slot] = page;
      if (fault_tally != FAULT_MAX) fault_tally = fault_tally + FAULT_W'(1);
    end
    r.hit = found;
    r.slot = 3'(slot);
    r.cold = cold;
    r.faults = fault_tally;
    return r;
  endfunction

  function automatic void note_mismatch(string field, logic [31:0] want, logic [31:0] got);
    $display("%0t ns: %s mismatch, expected %0h, actual %0h", $time, field, want, got);
    fail_cnt++;
  endfunction

  always @(posedge clk) begin : monitor
    ref_outcome_t want;
    if (!rst_n) begin
      for (int i = 0; i < FRAMES; i++) begin
        frame_page[i] = '0;
        frame_used[i] = 1'b0;
        frame_age[i] = '0;
      end
      fault_tally = '0;
      frame_limit = CNT_RESET;
      outcome_q.delete();
    end else begin
      if (cfg_valid && cfg_ready) frame_limit = cfg_frame_count;
      if (out_valid && !out_stall) begin
        if (outcome_q.size() == 0) begin
          $display({"%0t ns: result transfer with no reference pending, expected none, ",
                    "actual hit %0b slot %0d fill %0b faults %0d"},
                   $time, out_hit, out_frame_slot, out_filled_empty, out_fault_count);
          fail_cnt++;
        end else begin
          want = outcome_q.pop_front();
          if (out_hit !== want.hit) note_mismatch("hit", 32'(want.hit), 32'(out_hit));
          if (out_frame_slot !== want.slot)
            note_mismatch("frame_slot", 32'(want.slot), 32'(out_frame_slot));
          if (out_filled_empty !== want.cold)
            note_mismatch("filled_empty", 32'(want.cold), 32'(out_filled_empty));
          if (out_fault_count !== want.faults)
            note_mismatch("fault_count", want.faults, out_fault_count);
        end
      end
      if (in_valid && !in_stall) outcome_q.push_back(replace_page(in_page_id));
    end
    fails <= fail_cnt;
    pending <= outcome_q.size();
  end

endmodule

// ===== tb/testbench.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Stimulus and verdict for the lru page replacement block. A directed part
// covers cold fills, hits, evictions, saturated ages and out of range frame
// counts; random phases then replay small working sets mixed with stray
// pages under several frame counts and idle patterns on both channels.
// ----------------------------------------------------------------------------
module testbench;
  import lrupr_pkg::*;

  localparam int CYCLE_LIMIT     = 1_000_000;
  localparam int PHASES          = 10;
  localparam int REFS_PER_PHASE  = 140;
  localparam int POOL_SIZE       = 12;
  localparam int SETTLE_CYCLES   = 4 * FRAMES + 8;

  typedef enum int {IDLE_NONE, IDLE_SENDER, IDLE_RECEIVER, IDLE_BOTH} idle_mode_t;

  logic                 clk = 1'b0;
  logic                 rst_n = 1'b0;
  logic                 cfg_valid = 1'b0;
  logic                 cfg_ready;
  logic [CNT_W-1:0]     cfg_frame_count = CNT_RESET;
  logic                 in_valid = 1'b0;
  logic                 in_stall;
  logic [PAGE_BITS-1:0] in_page_id = '0;
  logic                 out_valid;
  logic                 out_stall = 1'b0;
  logic                 out_hit;
  logic [2:0]           out_frame_slot;
  logic                 out_filled_empty;
  logic [FAULT_W-1:0]   out_fault_count;
  int                   fails;
  int                   pending;
  int                   cycles = 0;
  int                   idle_pct = 0;
  int                   stall_pct = 0;
  logic [PAGE_BITS-1:0] page_pool [POOL_SIZE];

  always #5 clk = ~clk;

  lru_page_replacement DUT (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg_valid        (cfg_valid),
    .cfg_ready        (cfg_ready),
    .cfg_frame_count  (cfg_frame_count),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_page_id       (in_page_id),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_hit          (out_hit),
    .out_frame_slot   (out_frame_slot),
    .out_filled_empty (out_filled_empty),
    .out_fault_count  (out_fault_count)
  );

  lru_checker u_checker (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg_valid        (cfg_valid),
    .cfg_ready        (cfg_ready),
    .cfg_frame_count  (cfg_frame_count),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_page_id       (in_page_id),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_hit          (out_hit),
    .out_frame_slot   (out_frame_slot),
    .out_filled_empty (out_filled_empty),
    .out_fault_count  (out_fault_count),
    .fails            (fails),
    .pending          (pending)
  );

  always @(posedge clk) begin
    out_stall <= (stall_pct > 0) && ($urandom_range(99) < stall_pct);
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("lru_page_replacement test failed");
      $finish;
    end
  end

  task automatic set_idling(idle_mode_t mode);
    case (mode)
      IDLE_NONE: begin
        idle_pct = 0;
        stall_pct <= 0;
      end
      IDLE_SENDER: begin
        idle_pct = 45;
        stall_pct <= 0;
      end
      IDLE_RECEIVER: begin
        idle_pct = 0;
        stall_pct <= 45;
      end
      default: begin
        idle_pct = 6;
        stall_pct <= 6;
      end
    endcase
  endtask

  task automatic send_ref(logic [PAGE_BITS-1:0] page);
    while ($urandom_range(99) < idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_page_id <= page;
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
  endtask

  task automatic write_frame_count(logic [CNT_W-1:0] count);
    wait_drained();
    cfg_valid <= 1'b1;
    cfg_frame_count <= count;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
  endtask

  initial begin : stimulus
    logic [PAGE_BITS-1:0] warm_refs [13];
    logic [CNT_W-1:0]     count_plan [6];
    int                   working_set;
    warm_refs = '{16'h0000, 16'hFFFF, 16'h5555, 16'hAAAA, 16'h0001, 16'h8000,
                  16'h1234, 16'hFEDC, 16'h0000, 16'h4321, 16'hFFFF, 16'hFEDC,
                  16'hFEDC};
    count_plan = '{4'd8, 4'd1, 4'd0, 4'd15, 4'd4, 4'd9};
    for (int i = 0; i < POOL_SIZE; i++) page_pool[i] = PAGE_BITS'($urandom());
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // cold fills, refresh, eviction, repeat hit on the newest frame
    set_idling(IDLE_NONE);
    write_frame_count(4'd8);
    foreach (warm_refs[i]) send_ref(warm_refs[i]);
    // single frame, zero and oversized counts, then three frames
    write_frame_count(4'd1);
    send_ref(16'h0000);
    send_ref(16'h7777);
    send_ref(16'h7777);
    write_frame_count(4'd0);
    send_ref(16'h0000);
    send_ref(16'h0000);
    write_frame_count(4'd15);
    send_ref(16'h5555);
    send_ref(16'h1234);
    write_frame_count(4'd3);
    send_ref(16'hAAAA);
    send_ref(16'h0001);
    send_ref(16'h8000);

    for (int phase = 0; phase < PHASES; phase++) begin
      write_frame_count(phase < 6 ? count_plan[phase] : CNT_W'($urandom_range(15)));
      set_idling(idle_mode_t'(phase % 4));
      repeat ($urandom_range(4))
        page_pool[$urandom_range(POOL_SIZE - 1)] = PAGE_BITS'($urandom());
      working_set = $urandom_range(1, POOL_SIZE);
      for (int n = 0; n < REFS_PER_PHASE; n++) begin
        if (n % 20 == 19) working_set = $urandom_range(1, POOL_SIZE);
        if (n == REFS_PER_PHASE / 2) wait_drained();
        if ($urandom_range(99) < 85)
          send_ref(page_pool[$urandom_range(working_set - 1)]);
        else
          send_ref(PAGE_BITS'($urandom_range(65535)));
      end
    end

    wait_drained();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (fails == 0 && pending == 0) begin
      $display("lru_page_replacement test passed");
    end else begin
      $display("lru_page_replacement test failed");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
rtl/core/lrupr_pkg.sv
rtl/core/lrupr_frame_unit.sv
rtl/core/lru_page_replacement.sv
tb/lru_checker.sv
tb/testbench.sv
